// File: hdl/framebuffer_line_drawer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the frame store drawing engine
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef FRAMEBUFFER_LINE_DRAWER_ASSERT_SVH
`define FRAMEBUFFER_LINE_DRAWER_ASSERT_SVH

// Same-cycle implication: whenever a holds, b holds too.
`define FBLD_ASSERT_IMPL(label, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error(msg);

// Next-cycle implication: whenever a holds, b holds in the next cycle.
`define FBLD_ASSERT_NEXT(label, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error(msg);

`endif

// File: hdl/fbld_pkg.sv
// ----------------------------------------------------------------------------
// fbld_pkg
// Shared constants, command codes and handshake structs of the drawing engine.
// ----------------------------------------------------------------------------
package fbld_pkg;

  localparam int DISPLAY_WIDTH  = 128;
  localparam int DISPLAY_HEIGHT = 64;
  localparam int PAGE_COUNT     = (DISPLAY_HEIGHT + 7) / 8;
  localparam int STORE_BYTES    = DISPLAY_WIDTH * PAGE_COUNT;
  localparam int ADDR_W         = $clog2(STORE_BYTES);

  // Fixed field widths of the command port.
  localparam int X_W     = 7;
  localparam int Y_W     = 6;
  localparam int BADDR_W = 10;
  localparam int DATA_W  = 8;
  localparam int CNT_W   = 8;
  localparam int ERR_W   = X_W + 3;

  // Longest line visits one pixel per column of the coordinate range.
  localparam int MAX_PIXELS = 2 ** X_W;

  typedef enum logic [1:0] {
    CMD_PIXEL = 2'd0,
    CMD_LINE  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_CLEAR = 2'd3
  } fbld_cmd_t;

  typedef struct packed {
    logic [X_W-1:0] x;
    logic [Y_W-1:0] y;
  } fbld_pt_t;

  typedef struct packed {
    logic     load;
    logic     advance;
    fbld_pt_t p_start;
    fbld_pt_t p_end;
  } fbld_step_req_t;

  typedef struct packed {
    fbld_pt_t cur;
    logic     last;
  } fbld_step_sts_t;

endpackage

// File: hdl/framebuffer_line_drawer.sv
// ----------------------------------------------------------------------------
// framebuffer_line_drawer
// Monochrome page-organised frame store with pixel, line, read, clear commands.
//
//   channel  direction  ports                                   transfer when
//   in       input      in_cmd .. in_byte_address               in_valid & in_ready
//   out      output     out_read_data, out_pixels_written       out_valid & out_ready
//
// Every pixel is a read-modify-write of one store byte over the store's
// read port and write port: a read state, then a write state per pixel.
// Clear sweeps the store one byte per cycle.
// After reset the same sweep runs with in_ready low.
// A new command is taken while a finished result waits in the output
// register; its own result then holds until that register is free.
// ----------------------------------------------------------------------------
module framebuffer_line_drawer (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_cmd,
  input  logic [fbld_pkg::X_W-1:0]            in_x_start,
  input  logic [fbld_pkg::Y_W-1:0]            in_y_start,
  input  logic [fbld_pkg::X_W-1:0]            in_x_end,
  input  logic [fbld_pkg::Y_W-1:0]            in_y_end,
  input  logic                                in_pixel_on,
  input  logic [fbld_pkg::BADDR_W-1:0]        in_byte_address,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [fbld_pkg::DATA_W-1:0]         out_read_data,
  output logic [fbld_pkg::CNT_W-1:0]          out_pixels_written
);
  import fbld_pkg::*;

  `include "framebuffer_line_drawer_assert.svh"

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_CLEAR    = 6'b000010,
    ST_RD_WAIT  = 6'b000100,
    ST_PX_READ  = 6'b001000,
    ST_PX_WRITE = 6'b010000,
    ST_RESULT   = 6'b100000
  } state_t;

  state_t              state_r, state_nxt;
  logic [ADDR_W-1:0]   clr_addr_r, clr_addr_nxt;
  logic                clr_cmd_r, clr_cmd_nxt;
  logic                addr_ok_r, addr_ok_nxt;
  logic                pen_r, pen_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [DATA_W-1:0]   res_data_r, res_data_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]   out_data_r, out_data_nxt;
  logic [CNT_W-1:0]    out_count_r, out_count_nxt;

  fbld_step_req_t      step_req;
  fbld_step_sts_t      step_sts;

  logic                accept;
  fbld_cmd_t           cmd;
  logic                px_inside;
  logic [ADDR_W-1:0]   px_addr;
  logic [DATA_W-1:0]   px_mask;
  logic                res_free;

  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [DATA_W-1:0]   mem_wdata;
  logic [ADDR_W-1:0]   mem_raddr;
  logic [DATA_W-1:0]   mem_rdata;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign cmd      = fbld_cmd_t'(in_cmd);
  assign res_free = !out_valid_r || out_ready;

  // Current pixel of the walk: its store byte address, bit within the byte.
  always_comb begin
    px_inside = (int'(step_sts.cur.x) < DISPLAY_WIDTH) &&
                (int'(step_sts.cur.y) < DISPLAY_HEIGHT);
    px_addr   = ADDR_W'(int'(step_sts.cur.x) +
                        int'(step_sts.cur.y[Y_W-1:3]) * DISPLAY_WIDTH);
    px_mask   = DATA_W'(1) << step_sts.cur.y[2:0];
  end

  // Load endpoints on acceptance; a single pixel is a line of one point.
  always_comb begin
    step_req.load      = accept && (cmd == CMD_PIXEL || cmd == CMD_LINE);
    step_req.advance   = (state_r == ST_PX_WRITE) && !step_sts.last;
    step_req.p_start.x = in_x_start;
    step_req.p_start.y = in_y_start;
    step_req.p_end.x   = (cmd == CMD_LINE) ? in_x_end : in_x_start;
    step_req.p_end.y   = (cmd == CMD_LINE) ? in_y_end : in_y_start;
  end

  // Store port steering.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = px_addr;
    mem_wdata = pen_r ? (mem_rdata | px_mask) : (mem_rdata & ~px_mask);
    mem_raddr = px_addr;
    if (state_r == ST_IDLE) begin
      mem_raddr = ADDR_W'(in_byte_address);
    end
    if (state_r == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_r;
      mem_wdata = '0;
    end else if (state_r == ST_PX_WRITE) begin
      mem_we    = px_inside;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    clr_cmd_nxt   = clr_cmd_r;
    addr_ok_nxt   = addr_ok_r;
    pen_nxt       = pen_r;
    count_nxt     = count_r;
    res_data_nxt  = res_data_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_count_nxt = out_count_r;

    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          count_nxt    = '0;
          res_data_nxt = '0;
          unique case (cmd)
            CMD_PIXEL, CMD_LINE: begin
              pen_nxt   = (cmd == CMD_LINE) ? 1'b1 : in_pixel_on;
              state_nxt = ST_PX_READ;
            end
            CMD_READ: begin
              addr_ok_nxt = int'(in_byte_address) < STORE_BYTES;
              state_nxt   = ST_RD_WAIT;
            end
            CMD_CLEAR: begin
              clr_cmd_nxt  = 1'b1;
              clr_addr_nxt = '0;
              state_nxt    = ST_CLEAR;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + ADDR_W'(1);
        if (clr_addr_r == ADDR_W'(STORE_BYTES - 1)) begin
          // reset sweep gives no result; a clear command does
          state_nxt   = clr_cmd_r ? ST_RESULT : ST_IDLE;
          clr_cmd_nxt = 1'b0;
        end
      end
      ST_RD_WAIT: begin
        res_data_nxt = addr_ok_r ? mem_rdata : '0;
        state_nxt    = ST_RESULT;
      end
      ST_PX_READ: begin
        state_nxt = ST_PX_WRITE;
      end
      ST_PX_WRITE: begin
        if (px_inside) begin
          count_nxt = count_r + CNT_W'(1);
        end
        state_nxt = step_sts.last ? ST_RESULT : ST_PX_READ;
      end
      ST_RESULT: begin
        if (res_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_data_r;
          out_count_nxt = count_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      clr_cmd_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      clr_cmd_r   <= clr_cmd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: hold between updates, no reset needed.
  always_ff @(posedge clk) begin
    addr_ok_r   <= addr_ok_nxt;
    pen_r       <= pen_nxt;
    count_r     <= count_nxt;
    res_data_r  <= res_data_nxt;
    out_data_r  <= out_data_nxt;
    out_count_r <= out_count_nxt;
  end

  fbld_stepper u_stepper (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (step_req),
    .sts   (step_sts)
  );

  fbld_store u_store (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  assign out_valid          = out_valid_r;
  assign out_read_data      = out_data_r;
  assign out_pixels_written = out_count_r;

  `FBLD_ASSERT_IMPL(a_write_state, mem_we, (state_r == ST_CLEAR || state_r == ST_PX_WRITE), "store written outside a write slot")
  `FBLD_ASSERT_IMPL(a_clear_blocks, (state_r == ST_CLEAR), !in_ready, "command taken during clear sweep")
  `FBLD_ASSERT_IMPL(a_count_max, (state_r == ST_RESULT), (int'(count_r) <= MAX_PIXELS), "pixel count beyond longest line")
  `FBLD_ASSERT_NEXT(a_result_src, (state_r != ST_RESULT && !out_valid_r), !out_valid_r, "result raised outside result state")

endmodule

// File: hdl/fbld_store.sv
// ----------------------------------------------------------------------------
// fbld_store
// Page-organised frame store: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module fbld_store (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [fbld_pkg::ADDR_W-1:0] wr_addr,
  input  logic [fbld_pkg::DATA_W-1:0] wr_data,
  input  logic [fbld_pkg::ADDR_W-1:0] rd_addr,
  output logic [fbld_pkg::DATA_W-1:0] rd_data
);
  import fbld_pkg::*;

  logic [DATA_W-1:0] mem [STORE_BYTES];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: hdl/fbld_stepper.sv
// ----------------------------------------------------------------------------
// fbld_stepper
// Bresenham walker: loads two endpoints, presents one pixel, steps on request.
// ----------------------------------------------------------------------------
module fbld_stepper (
  input  logic                     clk,
  input  logic                     rst_n,
  input  fbld_pkg::fbld_step_req_t req,
  output fbld_pkg::fbld_step_sts_t sts
);
  import fbld_pkg::*;

  fbld_pt_t                 cur_r, cur_nxt;
  fbld_pt_t                 end_r, end_nxt;
  logic                     sx_neg_r, sx_neg_nxt;
  logic                     sy_neg_r, sy_neg_nxt;
  logic                     xmajor_r, xmajor_nxt;
  logic signed [ERR_W-1:0]  dx2_r, dx2_nxt;
  logic signed [ERR_W-1:0]  dy2_r, dy2_nxt;
  logic signed [ERR_W-1:0]  err_r, err_nxt;

  logic [X_W-1:0]           adx;
  logic [Y_W-1:0]           ady;
  logic signed [ERR_W-1:0]  e_dx, e_dy;
  logic [X_W-1:0]           x_step;
  logic [Y_W-1:0]           y_step;
  logic                     err_pos;

  always_comb begin
    adx = (req.p_end.x >= req.p_start.x) ? (req.p_end.x - req.p_start.x)
                                         : (req.p_start.x - req.p_end.x);
    ady = (req.p_end.y >= req.p_start.y) ? (req.p_end.y - req.p_start.y)
                                         : (req.p_start.y - req.p_end.y);
    e_dx = ERR_W'(adx);
    e_dy = ERR_W'(ady);
    x_step = sx_neg_r ? (cur_r.x - X_W'(1)) : (cur_r.x + X_W'(1));
    y_step = sy_neg_r ? (cur_r.y - Y_W'(1)) : (cur_r.y + Y_W'(1));
    err_pos = !err_r[ERR_W-1];

    cur_nxt    = cur_r;
    end_nxt    = end_r;
    sx_neg_nxt = sx_neg_r;
    sy_neg_nxt = sy_neg_r;
    xmajor_nxt = xmajor_r;
    dx2_nxt    = dx2_r;
    dy2_nxt    = dy2_r;
    err_nxt    = err_r;

    if (req.load) begin
      cur_nxt    = req.p_start;
      end_nxt    = req.p_end;
      sx_neg_nxt = req.p_end.x < req.p_start.x;
      sy_neg_nxt = req.p_end.y < req.p_start.y;
      xmajor_nxt = adx > X_W'(ady);
      dx2_nxt    = e_dx <<< 1;
      dy2_nxt    = e_dy <<< 1;
      // start at twice the minor span less the major span
      err_nxt    = (adx > X_W'(ady)) ? ((e_dy <<< 1) - e_dx) : ((e_dx <<< 1) - e_dy);
    end else if (req.advance) begin
      if (xmajor_r) begin
        cur_nxt.x = x_step;
        if (err_pos) begin
          cur_nxt.y = y_step;
          err_nxt   = err_r - dx2_r + dy2_r;
        end else begin
          err_nxt   = err_r + dy2_r;
        end
      end else begin
        cur_nxt.y = y_step;
        if (err_pos) begin
          cur_nxt.x = x_step;
          err_nxt   = err_r - dy2_r + dx2_r;
        end else begin
          err_nxt   = err_r + dx2_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xmajor_r <= 1'b0;
    end else begin
      xmajor_r <= xmajor_nxt;
    end
  end

  // Walk registers are payload; they are always loaded before use.
  always_ff @(posedge clk) begin
    cur_r    <= cur_nxt;
    end_r    <= end_nxt;
    sx_neg_r <= sx_neg_nxt;
    sy_neg_r <= sy_neg_nxt;
    dx2_r    <= dx2_nxt;
    dy2_r    <= dy2_nxt;
    err_r    <= err_nxt;
  end

  assign sts.cur  = cur_r;
  assign sts.last = xmajor_r ? (cur_r.x == end_r.x) : (cur_r.y == end_r.y);

endmodule

// File: tb/fbld_draw_checker.sv
// ----------------------------------------------------------------------------
// fbld_draw_checker
// Watches both channels of the drawing engine, keeps its own image of the
// frame store and compares every result with the value it predicts.
// ----------------------------------------------------------------------------
module fbld_draw_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [1:0]                    in_cmd,
  input  logic [fbld_pkg::X_W-1:0]      in_x_start,
  input  logic [fbld_pkg::Y_W-1:0]      in_y_start,
  input  logic [fbld_pkg::X_W-1:0]      in_x_end,
  input  logic [fbld_pkg::Y_W-1:0]      in_y_end,
  input  logic                          in_pixel_on,
  input  logic [fbld_pkg::BADDR_W-1:0]  in_byte_address,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [fbld_pkg::DATA_W-1:0]   out_read_data,
  input  logic [fbld_pkg::CNT_W-1:0]    out_pixels_written,
  output int unsigned                   mismatch_count,
  output int unsigned                   replies_owed
);
  import fbld_pkg::*;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic [CNT_W-1:0]  pixels_written;
  } draw_reply_t;

  logic [DATA_W-1:0] frame_img [STORE_BYTES];
  draw_reply_t       replies_due [$];

  // Set or clear one pixel of the image; returns 1 when it lies on the display.
  function automatic int unsigned plot(int x, int y, bit on);
    int idx;
    if (x < 0 || y < 0 || x >= DISPLAY_WIDTH || y >= DISPLAY_HEIGHT) return 0;
    idx = x + (y / 8) * DISPLAY_WIDTH;
    frame_img[idx][y % 8] = on;
    return 1;
  endfunction

  // Bresenham walk, both endpoints included; diagonals and points step in y.
  function automatic int unsigned trace_line(int xa, int ya, int xb, int yb);
    int          dx;
    int          dy;
    int          sx;
    int          sy;
    int          err;
    int unsigned n;
    dx = xb - xa;
    dy = yb - ya;
    sx = 1;
    sy = 1;
    if (dx < 0) begin
      dx = -dx;
      sx = -1;
    end
    if (dy < 0) begin
      dy = -dy;
      sy = -1;
    end
    dx = dx * 2;
    dy = dy * 2;
    n  = plot(xa, ya, 1'b1);
    if (dx > dy) begin
      err = dy - dx / 2;
      while (xa != xb) begin
        xa += sx;
        if (err >= 0) begin
          ya  += sy;
          err -= dx;
        end
        err += dy;
        n   += plot(xa, ya, 1'b1);
      end
    end else begin
      err = dx - dy / 2;
      while (ya != yb) begin
        if (err >= 0) begin
          xa  += sx;
          err -= dy;
        end
        ya  += sy;
        err += dx;
        n   += plot(xa, ya, 1'b1);
      end
    end
    return n;
  endfunction

  function automatic draw_reply_t apply_command(fbld_cmd_t op, int xs, int ys, int xe,
                                                int ye, bit on, int addr);
    draw_reply_t r;
    r = '0;
    case (op)
      CMD_PIXEL: r.pixels_written = CNT_W'(plot(xs, ys, on));
      CMD_LINE:  r.pixels_written = CNT_W'(trace_line(xs, ys, xe, ye));
      CMD_READ:  if (addr < STORE_BYTES) r.read_data = frame_img[addr];
      default:   foreach (frame_img[i]) frame_img[i] = '0;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    draw_reply_t exp_r;
    int unsigned errs;
    errs = 0;
    if (!rst_n) begin
      foreach (frame_img[i]) frame_img[i] = '0;
      replies_due.delete();
      mismatch_count <= 0;
    end else begin
      // results first: a command taken at this edge cannot already have its reply
      if (out_valid && out_ready) begin
        if (replies_due.size() == 0) begin
          $error("result transfer with no command outstanding (read_data %0d, pixels %0d)",
                 out_read_data, out_pixels_written);
          errs += 1;
        end else begin
          exp_r = replies_due.pop_front();
          if (out_read_data !== exp_r.read_data) begin
            $error("read_data: expected %0d, got %0d", exp_r.read_data, out_read_data);
            errs += 1;
          end
          if (out_pixels_written !== exp_r.pixels_written) begin
            $error("pixels_written: expected %0d, got %0d",
                   exp_r.pixels_written, out_pixels_written);
            errs += 1;
          end
        end
      end
      if (in_valid && in_ready)
        replies_due.push_back(apply_command(fbld_cmd_t'(in_cmd), in_x_start, in_y_start,
                                            in_x_end, in_y_end, in_pixel_on,
                                            in_byte_address));
      mismatch_count <= mismatch_count + errs;
    end
    replies_owed <= replies_due.size();
  end

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives draw, pixel, read and clear commands into the frame store engine
// under changing idle and stall patterns; the checker beside the block
// predicts every reply and the verdict is given here.
// ----------------------------------------------------------------------------
module tb;
  import fbld_pkg::*;

  // Longest legal quiet stretch is a store clear plus handshake gaps, or the
  // final settle wait; allow many times that.
  localparam int QUIET_LIMIT  = 20000;
  localparam int SETTLE_WAIT  = 1100;
  localparam int PHASE_ITEMS  = 170;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [1:0]          in_cmd;
  logic [X_W-1:0]      in_x_start;
  logic [Y_W-1:0]      in_y_start;
  logic [X_W-1:0]      in_x_end;
  logic [Y_W-1:0]      in_y_end;
  logic                in_pixel_on;
  logic [BADDR_W-1:0]  in_byte_address;
  logic                out_valid;
  logic                out_ready;
  logic [DATA_W-1:0]   out_read_data;
  logic [CNT_W-1:0]    out_pixels_written;

  int unsigned mismatch_count;
  int unsigned replies_owed;
  int          gap_pct;
  int          stall_pct;
  int          quiet_cycles;

  // Coordinates taken from the endpoints of the last drawing command; reads aim at them most of the time.
  int          hot_x;
  int          hot_y;

  framebuffer_line_drawer u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_cmd             (in_cmd),
    .in_x_start         (in_x_start),
    .in_y_start         (in_y_start),
    .in_x_end           (in_x_end),
    .in_y_end           (in_y_end),
    .in_pixel_on        (in_pixel_on),
    .in_byte_address    (in_byte_address),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_read_data      (out_read_data),
    .out_pixels_written (out_pixels_written)
  );

  fbld_draw_checker u_draw_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_cmd             (in_cmd),
    .in_x_start         (in_x_start),
    .in_y_start         (in_y_start),
    .in_x_end           (in_x_end),
    .in_y_end           (in_y_end),
    .in_pixel_on        (in_pixel_on),
    .in_byte_address    (in_byte_address),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_read_data      (out_read_data),
    .out_pixels_written (out_pixels_written),
    .mismatch_count     (mismatch_count),
    .replies_owed       (replies_owed)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Receiver: stall at random with the current percentage. stall_pct is only
  // changed by nonblocking assignment, so this block always sees a settled value.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Watchdog: count cycles without any transfer on either channel.
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Issue one command and hold it until the transfer. Call right after a
  // rising edge; returns at the edge of the transfer.
  task automatic issue(fbld_cmd_t op, int xs, int ys, int xe, int ye, bit on, int addr);
    // drop valid for a random number of cycles first
    while (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_cmd          <= op;
    in_x_start      <= X_W'(xs);
    in_y_start      <= Y_W'(ys);
    in_x_end        <= X_W'(xe);
    in_y_end        <= Y_W'(ye);
    in_pixel_on     <= on;
    in_byte_address <= BADDR_W'(addr);
    do @(posedge clk); while (!in_ready);
  endtask

  // Hold the sender off until every reply owed has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (replies_owed != 0);
  endtask

  // Random commands: mostly short lines and pixels around the display, reads
  // aimed at recent drawing, a rare full clear.
  task automatic run_phase(int n, int idle_in, int stall_out);
    int pick;
    int xs;
    int ys;
    int xe;
    int ye;
    int addr;
    bit on;
    gap_pct   = idle_in;
    stall_pct <= stall_out;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      xs   = $urandom_range(0, DISPLAY_WIDTH - 1);
      ys   = $urandom_range(0, DISPLAY_HEIGHT - 1);
      on   = $urandom_range(0, 1);
      addr = $urandom_range(0, STORE_BYTES - 1);
      if ($urandom_range(0, 9) < 7) begin
        // short line around the start point, clamped to the display
        xe = xs + $urandom_range(0, 24) - 12;
        ye = ys + $urandom_range(0, 16) - 8;
        if (xe < 0) xe = 0;
        if (xe > DISPLAY_WIDTH - 1) xe = DISPLAY_WIDTH - 1;
        if (ye < 0) ye = 0;
        if (ye > DISPLAY_HEIGHT - 1) ye = DISPLAY_HEIGHT - 1;
      end else begin
        xe = $urandom_range(0, DISPLAY_WIDTH - 1);
        ye = $urandom_range(0, DISPLAY_HEIGHT - 1);
      end
      if (pick < 35) begin
        issue(CMD_LINE, xs, ys, xe, ye, on, addr);
        hot_x = $urandom_range(0, 1) ? xs : xe;
        hot_y = $urandom_range(0, 1) ? ys : ye;
      end else if (pick < 60) begin
        issue(CMD_PIXEL, xs, ys, xe, ye, on, addr);
        hot_x = xs;
        hot_y = ys;
      end else if (pick < 97) begin
        // aim most reads at the byte holding a recently drawn pixel
        if ($urandom_range(0, 9) < 7) addr = hot_x + (hot_y / 8) * DISPLAY_WIDTH;
        issue(CMD_READ, xs, ys, xe, ye, on, addr);
      end else begin
        issue(CMD_CLEAR, xs, ys, xe, ye, on, addr);
      end
    end
  endtask

  initial begin
    // drive every input to a known value from time zero
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_cmd          <= CMD_READ;
    in_x_start      <= '0;
    in_y_start      <= '0;
    in_x_end        <= '0;
    in_y_end        <= '0;
    in_pixel_on     <= 1'b0;
    in_byte_address <= '0;
    out_ready       <= 1'b0;
    stall_pct       <= 0;
    gap_pct         = 0;
    hot_x           = 0;
    hot_y           = 0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty store, two opposite corners of the field ranges, pixel clear,
    // longest horizontal and vertical lines, diagonals both ways, a single point,
    // steep and shallow lines in negative directions, then clear and read back.
    issue(CMD_READ,  0,   0,  0,   0,  0, 0);
    issue(CMD_READ,  0,   0,  0,   0,  0, STORE_BYTES - 1);
    issue(CMD_PIXEL, 0,   0,  0,   0,  1, 0);
    issue(CMD_PIXEL, 127, 63, 127, 63, 1, 1023);
    issue(CMD_READ,  0,   0,  0,   0,  0, 0);
    issue(CMD_READ,  0,   0,  0,   0,  0, STORE_BYTES - 1);
    issue(CMD_PIXEL, 127, 63, 0,   0,  0, 0);
    issue(CMD_READ,  0,   0,  0,   0,  0, STORE_BYTES - 1);
    issue(CMD_LINE,  0,   5,  127, 5,  1, 0);
    issue(CMD_LINE,  3,   0,  3,   63, 1, 0);
    issue(CMD_LINE,  10,  10, 20,  20, 1, 0);
    issue(CMD_LINE,  40,  20, 30,  10, 1, 0);
    issue(CMD_LINE,  50,  30, 50,  30, 1, 0);
    issue(CMD_LINE,  127, 63, 0,   0,  1, 0);
    issue(CMD_LINE,  100, 2,  90,  60, 1, 0);
    issue(CMD_LINE,  5,   60, 120, 50, 1, 0);
    issue(CMD_READ,  0,   0,  0,   0,  0, 5);
    issue(CMD_READ,  0,   0,  0,   0,  0, 3 + 7 * DISPLAY_WIDTH);
    issue(CMD_READ,  0,   0,  0,   0,  0, 95 + 3 * DISPLAY_WIDTH);
    issue(CMD_CLEAR, 0,   0,  0,   0,  0, 0);
    issue(CMD_READ,  0,   0,  0,   0,  0, 5);
    issue(CMD_PIXEL, 127, 0,  127, 63, 0, 1023);
    issue(CMD_PIXEL, 127, 0,  127, 63, 1, 1023);
    issue(CMD_READ,  0,   0,  0,   0,  0, 127);

    // Random phases: no idling, sender idle, receiver stalling, both; hold the
    // sender off between phases until every reply has come back.
    run_phase(PHASE_ITEMS, 0, 0);
    drain();
    run_phase(PHASE_ITEMS, 62, 0);
    drain();
    run_phase(PHASE_ITEMS, 0, 62);
    drain();
    run_phase(PHASE_ITEMS, 35, 35);
    drain();

    // let any stray reply show up before the verdict
    repeat (SETTLE_WAIT) @(posedge clk);
    if (mismatch_count == 0 && replies_owed == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
